// ----- rtl/core/blms_pkg.sv -----
// Shared types and constants of the battery mode load shedder.
`timescale 1ns / 1ps
package blms_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_READ    = 3'd1,
    KIND_CYCLE   = 3'd2,
    KIND_DISCH   = 3'd3,
    KIND_CHARGE  = 3'd4,
    KIND_RESTART = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    OP_NORMAL  = 2'd0,
    OP_SAVING  = 2'd1,
    OP_REDUCED = 2'd2,
    OP_RESERVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_CAPACITY    = 2'd0,
    REG_POWER_LIMIT = 2'd1,
    REG_DEVICES     = 2'd2
  } reg_e;

  localparam logic [6:0]  PCT_SCALE   = 7'd100;
  localparam logic [5:0]  PCT_HIGH    = 6'd60;
  localparam logic [5:0]  PCT_MEDIUM  = 6'd30;
  localparam logic [5:0]  PCT_LOW     = 6'd10;
  localparam logic [23:0] DIV5_MUL    = 24'd13421773;
  localparam int          DIV5_SHIFT  = 26;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] device_power_in;
    logic [1:0]  device_priority_in;
    logic        switch_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        mode_changed;
    logic [23:0] battery_level;
    logic [19:0] total_power;
    logic        overloaded;
    logic [15:0] overload_count;
    logic [15:0] mode_change_total;
    logic [47:0] system_energy;
    logic [4:0]  shed_count;
    logic        device_on_out;
    logic [39:0] device_energy_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [23:0] value;
  } cfg_item_t;

endpackage

// ----- rtl/core/blms_chan_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps
interface blms_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/blms_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module blms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/battery_mode_load_shedder_core.sv -----
// Top level: device table, battery state and the control cycle sequencer.
// Write, discharge and restart items go straight to S_DONE; read and charge pass S_RDDEV or S_CHG.
// A control cycle walks the first n table entries (n devices in use): once to shed by
// mode, then while overloaded once per priority level from the highest down to 1, and once
// for energy; the table walks go one entry per cycle through the table RAM read port.
// One item at a time; a finished result waits in the output register.
// Reset clears the control and battery state, the on flags and the energy valid bits; no clearing pass.
`timescale 1ns / 1ps
module battery_mode_load_shedder_core #(
  parameter int MAX_DEVICES     = 16,
  parameter int PRIORITY_LEVELS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blms_chan_if.sink   in_i,
  blms_chan_if.source out_o,
  blms_chan_if.sink   cfg_i
);
  import blms_pkg::*;

  localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CW = $clog2(MAX_DEVICES + 1);
  localparam int PW = $clog2(PRIORITY_LEVELS);
  localparam int TW = 16 + CW;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RDDEV  = 11'b00000000010,
    S_CHG    = 11'b00000000100,
    S_MUL    = 11'b00000001000,
    S_MODE   = 11'b00000010000,
    S_SHED   = 11'b00000100000,
    S_CHECK  = 11'b00001000000,
    S_OVER   = 11'b00010000000,
    S_ESUM   = 11'b00100000000,
    S_ENERGY = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [23:0] cap_q, cap_d;
  logic [19:0] limit_q, limit_d;
  logic [4:0]  diu_q, diu_d;

  logic [23:0] battery_q, battery_d;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] mchg_q, mchg_d;
  logic [15:0] warn_q, warn_d;
  logic [19:0] psum_q, psum_d;
  logic [47:0] esum_q, esum_d;

  logic [MAX_DEVICES-1:0] on_q, on_d;
  logic [MAX_DEVICES-1:0] ev_q, ev_d;

  logic        changed_q, changed_d;
  logic        over_q, over_d;
  logic [4:0]  shed_q, shed_d;
  logic        on_out_q, on_out_d;
  logic [39:0] en_out_q, en_out_d;

  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [PW-1:0] pri_q, pri_d;
  logic          done_q, done_d;
  logic [TW-1:0] total_q, total_d;
  logic [3:0]    slot_q, slot_d;
  logic [21:0]   quot_q, quot_d;
  logic [30:0]   b100_q, b100_d;
  logic [30:0]   c60_q, c60_d;
  logic [30:0]   c30_q, c30_d;
  logic [30:0]   c10_q, c10_d;

  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic          in_acc;
  in_item_t      item;
  logic          slot_ok;
  logic [AW-1:0] slot_a;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] e_raddr;
  logic [17:0]   tbl_rdata;
  logic [39:0]   en_rdata;
  logic [15:0]   dev_pow;
  logic [PW-1:0] dev_pri;
  logic          dev_on;
  logic [39:0]   dev_en;
  logic          tbl_we;
  logic          en_we;
  logic [39:0]   en_wdata;
  logic [40:0]   en_sum;
  logic [47:0]   prod;
  logic [24:0]   chg_sum;
  logic [TW-1:0] sub_total;
  logic [19:0]   ps_sat;
  logic [48:0]   esum_sum;
  logic [1:0]    mode_new;
  logic          hit;
  logic          walk_end;

  assign item    = in_i.data;
  assign in_acc  = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign slot_ok  = 32'(item.slot) < MAX_DEVICES;
  assign slot_a   = AW'(item.slot);
  assign idx_a    = idx_q[AW-1:0];
  assign rd_addr  = (32'(idx_d) < MAX_DEVICES) ? idx_d[AW-1:0] : '0;
  assign e_raddr  = (state_q == S_IDLE) ? slot_a : rd_addr;
  assign walk_end = (idx_q == n_q);

  assign tbl_we = in_acc && (item.kind == KIND_WRITE) && slot_ok;

  blms_ram #(.Width(18), .Depth(MAX_DEVICES)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot_a),
    .wdata_i ({item.device_power_in, item.device_priority_in}),
    .raddr_i (rd_addr),
    .rdata_o (tbl_rdata)
  );

  blms_ram #(.Width(40), .Depth(MAX_DEVICES)) u_energy (
    .clk_i   (clk_i),
    .we_i    (en_we),
    .waddr_i (idx_a),
    .wdata_i (en_wdata),
    .raddr_i (e_raddr),
    .rdata_o (en_rdata)
  );

  assign dev_pow  = tbl_rdata[17:2];
  assign dev_pri  = PW'(tbl_rdata[1:0]);
  assign dev_on   = on_q[idx_a];
  assign dev_en   = ev_q[idx_a] ? en_rdata : '0;
  assign en_sum   = {1'b0, dev_en} + 41'(dev_pow);
  assign en_wdata = en_sum[40] ? '1 : en_sum[39:0];
  assign en_we    = (state_q == S_ENERGY) && !walk_end && dev_on;

  assign prod      = 48'(cap_q) * 48'(DIV5_MUL);
  assign chg_sum   = {1'b0, battery_q} + 25'(quot_q);
  assign sub_total = total_q - TW'(dev_pow);
  assign ps_sat    = (32'(total_q) > 32'hFFFFF) ? '1 : total_q[19:0];
  assign esum_sum  = {1'b0, esum_q} + 49'(ps_sat);

  always_comb begin
    if (b100_q > c60_q) begin
      mode_new = OP_NORMAL;
    end else if (b100_q > c30_q) begin
      mode_new = OP_SAVING;
    end else if (b100_q > c10_q) begin
      mode_new = OP_REDUCED;
    end else begin
      mode_new = OP_RESERVE;
    end
  end

  always_comb begin
    case (mode_q)
      OP_SAVING:   hit = (dev_pri == PW'(PRIORITY_LEVELS - 1));
      OP_REDUCED,
      OP_RESERVE:  hit = (dev_pri != '0);
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    limit_d     = limit_q;
    diu_d       = diu_q;
    battery_d   = battery_q;
    mode_d      = mode_q;
    mchg_d      = mchg_q;
    warn_d      = warn_q;
    psum_d      = psum_q;
    esum_d      = esum_q;
    on_d        = on_q;
    ev_d        = ev_q;
    changed_d   = changed_q;
    over_d      = over_q;
    shed_d      = shed_q;
    on_out_d    = on_out_q;
    en_out_d    = en_out_q;
    n_d         = n_q;
    idx_d       = idx_q;
    pri_d       = pri_q;
    done_d      = done_q;
    total_d     = total_q;
    slot_d      = slot_q;
    quot_d      = quot_q;
    b100_d      = b100_q;
    c60_d       = c60_q;
    c30_d       = c30_q;
    c10_d       = c10_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        REG_CAPACITY:    cap_d   = cfg_i.data.value;
        REG_POWER_LIMIT: limit_d = cfg_i.data.value[19:0];
        REG_DEVICES:     diu_d   = cfg_i.data.value[4:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          changed_d = 1'b0;
          over_d    = 1'b0;
          shed_d    = '0;
          on_out_d  = 1'b0;
          en_out_d  = '0;
          slot_d    = item.slot;
          state_d   = S_DONE;
          case (item.kind)
            KIND_WRITE: begin
              if (slot_ok) begin
                on_d[slot_a] = item.switch_on;
              end
            end
            KIND_READ: state_d = S_RDDEV;
            KIND_CYCLE: begin
              if (cap_q != '0) begin
                n_d = (7'(diu_q) > 7'(MAX_DEVICES)) ? CW'(MAX_DEVICES) : CW'(diu_q);
                state_d = S_MUL;
              end
            end
            KIND_DISCH: begin
              battery_d = (32'(battery_q) > 32'(psum_q)) ? battery_q - 24'(psum_q) : '0;
            end
            KIND_CHARGE: begin
              quot_d  = prod[DIV5_SHIFT +: 22];
              state_d = S_CHG;
            end
            KIND_RESTART: begin
              battery_d = cap_q;
              mchg_d    = '0;
              esum_d    = '0;
            end
            default: ;
          endcase
        end
      end
      S_RDDEV: begin
        if (32'(slot_q) < MAX_DEVICES) begin
          on_out_d = on_q[AW'(slot_q)];
          en_out_d = ev_q[AW'(slot_q)] ? en_rdata : '0;
        end
        state_d = S_DONE;
      end
      S_CHG: begin
        battery_d = (chg_sum > 25'(cap_q)) ? cap_q : chg_sum[23:0];
        state_d   = S_DONE;
      end
      S_MUL: begin
        b100_d  = 31'(battery_q) * 31'(PCT_SCALE);
        c60_d   = 31'(cap_q) * 31'(PCT_HIGH);
        c30_d   = 31'(cap_q) * 31'(PCT_MEDIUM);
        c10_d   = 31'(cap_q) * 31'(PCT_LOW);
        state_d = S_MODE;
      end
      S_MODE: begin
        if (mode_new != mode_q) begin
          changed_d = 1'b1;
          if (mchg_q != '1) begin
            mchg_d = mchg_q + 16'd1;
          end
        end
        mode_d  = mode_new;
        idx_d   = '0;
        total_d = '0;
        state_d = S_SHED;
      end
      S_SHED: begin
        if (walk_end) begin
          state_d = S_CHECK;
        end else begin
          if (dev_on) begin
            if (hit) begin
              on_d[idx_a] = 1'b0;
              shed_d      = shed_q + 5'd1;
            end else begin
              total_d = total_q + TW'(dev_pow);
            end
          end
          idx_d = idx_q + CW'(1);
        end
      end
      S_CHECK: begin
        if (32'(total_q) > 32'(limit_q)) begin
          over_d = 1'b1;
          if (warn_q != '1) begin
            warn_d = warn_q + 16'd1;
          end
          pri_d   = PW'(PRIORITY_LEVELS - 1);
          done_d  = 1'b0;
          idx_d   = '0;
          state_d = S_OVER;
        end else begin
          state_d = S_ESUM;
        end
      end
      S_OVER: begin
        if (walk_end) begin
          if (done_q || pri_q == PW'(1)) begin
            state_d = S_ESUM;
          end else begin
            pri_d = pri_q - PW'(1);
            idx_d = '0;
          end
        end else begin
          if (!done_q && dev_on && dev_pri == pri_q) begin
            on_d[idx_a] = 1'b0;
            shed_d      = shed_q + 5'd1;
            total_d     = sub_total;
            if (32'(sub_total) <= 32'(limit_q)) begin
              done_d = 1'b1;
            end
          end
          idx_d = idx_q + CW'(1);
        end
      end
      S_ESUM: begin
        psum_d  = ps_sat;
        esum_d  = esum_sum[48] ? '1 : esum_sum[47:0];
        idx_d   = '0;
        state_d = S_ENERGY;
      end
      S_ENERGY: begin
        if (walk_end) begin
          state_d = S_DONE;
        end else begin
          if (dev_on) begin
            ev_d[idx_a] = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.mode              = mode_q;
          out_d.mode_changed      = changed_q;
          out_d.battery_level     = battery_q;
          out_d.total_power       = psum_q;
          out_d.overloaded        = over_q;
          out_d.overload_count    = warn_q;
          out_d.mode_change_total = mchg_q;
          out_d.system_energy     = esum_q;
          out_d.shed_count        = shed_q;
          out_d.device_on_out     = on_out_q;
          out_d.device_energy_out = en_out_q;
          out_valid_d             = 1'b1;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= '0;
      limit_q     <= '0;
      diu_q       <= '0;
      battery_q   <= '0;
      mode_q      <= OP_NORMAL;
      mchg_q      <= '0;
      warn_q      <= '0;
      psum_q      <= '0;
      esum_q      <= '0;
      on_q        <= '0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      pri_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      limit_q     <= limit_d;
      diu_q       <= diu_d;
      battery_q   <= battery_d;
      mode_q      <= mode_d;
      mchg_q      <= mchg_d;
      warn_q      <= warn_d;
      psum_q      <= psum_d;
      esum_q      <= esum_d;
      on_q        <= on_d;
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      pri_q       <= pri_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    changed_q <= changed_d;
    over_q    <= over_d;
    shed_q    <= shed_d;
    on_out_q  <= on_out_d;
    en_out_q  <= en_out_d;
    total_q   <= total_d;
    slot_q    <= slot_d;
    quot_q    <= quot_d;
    b100_q    <= b100_d;
    c60_q     <= c60_d;
    c30_q     <= c30_d;
    c10_q     <= c10_d;
    out_q     <= out_d;
  end
endmodule

// ----- rtl/core/blms_checker.sv -----
// Port-level assertions for the load shedder core, bound to the top level.
`timescale 1ns / 1ps
module blms_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input blms_pkg::out_item_t  out_data
);
  import blms_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still in work");

  a_mode_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.mode_changed |-> out_data.mode_change_total != '0)
    else $error("mode change not counted");

  a_over_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.overloaded |-> out_data.overload_count != '0)
    else $error("overload not counted");
endmodule

bind battery_mode_load_shedder_core blms_checker u_blms_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
